FILE: design/mvna_pkg.sv
// shared types, widths and codes of the vertex normal accumulator
package mvna_pkg;

  // vertex store depth default
  localparam int VERTEX_COUNT_DEF = 1024;

  // field widths
  localparam int IDX_W = 10;
  localparam int POS_W = 32;
  localparam int NRM_W = 16;
  localparam int SUM_W = 24;

  // item actions
  localparam logic [1:0] ACT_WRITE = 2'd0;
  localparam logic [1:0] ACT_TRI   = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;
  localparam logic [1:0] ACT_CLEAR = 2'd3;

  // fixed point constants
  localparam logic [NRM_W-1:0] ONE_Q14 = 16'd16384;

  // result of the unit vector engine
  typedef struct packed {
    logic                        done;
    logic                        zero;
    logic [2:0][NRM_W-1:0]       u;
  } norm_res_t;

endpackage

FILE: design/mvna_if.sv
// item channels: triangle/position/read/clear requests in, normals out
interface mvna_in_if;
  import mvna_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [1:0]               action;
  logic [IDX_W-1:0]         index_a;
  logic [IDX_W-1:0]         index_b;
  logic [IDX_W-1:0]         index_c;
  logic signed [POS_W-1:0]  pos_x;
  logic signed [POS_W-1:0]  pos_y;
  logic signed [POS_W-1:0]  pos_z;
  modport source (output valid, action, index_a, index_b, index_c, pos_x, pos_y, pos_z,
                  input ready);
  modport sink (input valid, action, index_a, index_b, index_c, pos_x, pos_y, pos_z,
                output ready);
endinterface

interface mvna_out_if;
  import mvna_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [NRM_W-1:0]  normal_x;
  logic signed [NRM_W-1:0]  normal_y;
  logic signed [NRM_W-1:0]  normal_z;
  logic                     degenerate;
  modport source (output valid, normal_x, normal_y, normal_z, degenerate, input ready);
  modport sink (input valid, normal_x, normal_y, normal_z, degenerate, output ready);
endinterface

FILE: design/mvna_ram.sv
// generic simple dual port ram with registered read
module mvna_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/mvna_norm.sv
// unit vector engine: normalize shift, sum of squares, bit-serial root, serial divide
module mvna_norm (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [2:0][63:0]       vec,
  output mvna_pkg::norm_res_t    res
);
  import mvna_pkg::*;

  localparam logic [2:0] N_IDLE  = 3'd0;
  localparam logic [2:0] N_CHK   = 3'd1;
  localparam logic [2:0] N_SHIFT = 3'd2;
  localparam logic [2:0] N_SQ    = 3'd3;
  localparam logic [2:0] N_SQRT  = 3'd4;
  localparam logic [2:0] N_DINIT = 3'd5;
  localparam logic [2:0] N_DIV   = 3'd6;
  localparam logic [2:0] N_DONE  = 3'd7;

  logic [2:0]             st_r;
  logic [2:0][63:0]       m_r;
  logic [2:0]             sgn_r;
  logic [4:0]             cnt_r;
  logic [1:0]             comp_r;
  logic [61:0]            sum_r;
  logic [59:0]            sq_r;
  logic [61:0]            rt_n_r;
  logic [62:0]            rt_r;
  logic [32:0]            rem_r;
  logic [15:0]            num_r;
  logic [NRM_W-1:0]       q_r;
  logic [2:0][NRM_W-1:0]  u_r;
  logic                   zero_r;

  logic                   hi_any;
  logic                   lo_all;
  logic [1:0]             sq_sel;
  logic [29:0]            sq_op;
  logic [59:0]            sq;
  logic [62:0]            bitv;
  logic [62:0]            rt_t;
  logic                   rt_ge;
  logic [31:0]            len;
  logic [44:0]            numer;
  logic [32:0]            dv_t;
  logic                   dv_ge;
  logic [NRM_W-1:0]       q_nxt;
  logic [NRM_W-1:0]       q_clamp;

  // range tests for the normalizing shift
  always_comb begin
    hi_any = 1'b0;
    lo_all = 1'b1;
    for (int i = 0; i < 3; i++) begin
      hi_any = hi_any | (|m_r[i][63:30]);
      lo_all = lo_all & ~(|m_r[i][63:29]);
    end
  end

  // shared squarer
  assign sq_sel = (cnt_r[1:0] == 2'd3) ? 2'd0 : cnt_r[1:0];
  assign sq_op  = m_r[sq_sel][29:0];
  assign sq     = 60'(sq_op) * 60'(sq_op);

  // one root step per cycle
  assign bitv  = 63'(1) << {cnt_r, 1'b0};
  assign rt_t  = rt_r + bitv;
  assign rt_ge = {1'b0, rt_n_r} >= rt_t;
  assign len   = rt_r[31:0];

  // one quotient bit per cycle, rounding half up through the numerator
  assign numer   = {1'b0, m_r[comp_r][29:0], 14'd0} + 45'(len >> 1);
  assign dv_t    = {rem_r[31:0], num_r[15]};
  assign dv_ge   = dv_t >= {1'b0, len};
  assign q_nxt   = {q_r[NRM_W-2:0], dv_ge};
  assign q_clamp = (q_nxt > ONE_Q14) ? ONE_Q14 : q_nxt;

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= N_IDLE;
    end else begin
      case (st_r)
        N_IDLE: begin
          if (start) begin
            for (int i = 0; i < 3; i++) begin
              sgn_r[i] <= vec[i][63];
              m_r[i]   <= vec[i][63] ? (~vec[i] + 64'd1) : vec[i];
            end
            st_r <= N_CHK;
          end
        end
        N_CHK: begin
          if (m_r == '0) begin
            zero_r <= 1'b1;
            u_r    <= '0;
            st_r   <= N_DONE;
          end else begin
            zero_r <= 1'b0;
            st_r   <= N_SHIFT;
          end
        end
        N_SHIFT: begin
          if (hi_any) begin
            for (int i = 0; i < 3; i++) m_r[i] <= m_r[i] >> 1;
          end else if (lo_all) begin
            for (int i = 0; i < 3; i++) m_r[i] <= m_r[i] << 1;
          end else begin
            cnt_r <= '0;
            sum_r <= '0;
            st_r  <= N_SQ;
          end
        end
        N_SQ: begin
          if (cnt_r != 5'd3) begin
            sq_r <= sq;
          end
          if (cnt_r != 5'd0) begin
            sum_r <= sum_r + 62'(sq_r);
          end
          if (cnt_r == 5'd3) begin
            rt_n_r <= sum_r + 62'(sq_r);
            rt_r   <= '0;
            cnt_r  <= 5'd31;
            st_r   <= N_SQRT;
          end else begin
            cnt_r <= cnt_r + 5'd1;
          end
        end
        N_SQRT: begin
          if (rt_ge) begin
            rt_n_r <= rt_n_r - rt_t[61:0];
            rt_r   <= (rt_r >> 1) + bitv;
          end else begin
            rt_r <= rt_r >> 1;
          end
          cnt_r <= cnt_r - 5'd1;
          if (cnt_r == 5'd0) begin
            comp_r <= '0;
            st_r   <= N_DINIT;
          end
        end
        N_DINIT: begin
          rem_r <= 33'(numer[44:16]);
          num_r <= numer[15:0];
          q_r   <= '0;
          cnt_r <= '0;
          st_r  <= N_DIV;
        end
        N_DIV: begin
          rem_r <= dv_ge ? (dv_t - {1'b0, len}) : dv_t;
          num_r <= {num_r[14:0], 1'b0};
          q_r   <= q_nxt;
          cnt_r <= cnt_r + 5'd1;
          if (cnt_r == 5'd15) begin
            u_r[comp_r] <= sgn_r[comp_r] ? (~q_clamp + 16'd1) : q_clamp;
            if (comp_r == 2'd2) begin
              st_r <= N_DONE;
            end else begin
              comp_r <= comp_r + 2'd1;
              st_r   <= N_DINIT;
            end
          end
        end
        N_DONE: begin
          st_r <= N_IDLE;
        end
        default: begin
          st_r <= N_IDLE;
        end
      endcase
    end
  end

  assign res.done = (st_r == N_DONE);
  assign res.zero = zero_r;
  assign res.u    = u_r;

endmodule

FILE: design/mesh_vertex_normal_accumulator.sv
// top level: position and sum stores, triangle sequencer and read path
// unit vector engine: normalizing shifts, 32 root steps and three serial divides
// throughput: one item at a time; the next item is taken when the sequencer is idle
// reset: synchronous active low; a clearing pass then zeroes every sum
module mesh_vertex_normal_accumulator #(
  parameter int VERTEX_COUNT = mvna_pkg::VERTEX_COUNT_DEF
) (
  input logic        clk,
  input logic        rst_n,
  mvna_in_if.sink    in_ch,
  mvna_out_if.source out_ch
);
  import mvna_pkg::*;

  localparam int AW = $clog2(VERTEX_COUNT);

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_WPOS  = 4'd2;
  localparam logic [3:0] S_P0    = 4'd3;
  localparam logic [3:0] S_P1    = 4'd4;
  localparam logic [3:0] S_P2    = 4'd5;
  localparam logic [3:0] S_P3    = 4'd6;
  localparam logic [3:0] S_EDGE  = 4'd7;
  localparam logic [3:0] S_MUL   = 4'd8;
  localparam logic [3:0] S_NGO   = 4'd9;
  localparam logic [3:0] S_NWAIT = 4'd10;
  localparam logic [3:0] S_SRD   = 4'd11;
  localparam logic [3:0] S_SWR   = 4'd12;
  localparam logic [3:0] S_RSUM  = 4'd13;
  localparam logic [3:0] S_OUT   = 4'd14;

  logic [3:0]               st_r;
  logic [AW-1:0]            clr_cnt_r;
  logic [1:0]               act_r;
  logic [IDX_W-1:0]         ia_r, ib_r, ic_r;
  logic [3*POS_W-1:0]       pin_r;
  logic [3*POS_W-1:0]       posa_r, posb_r, posc_r;
  logic [5:0]               esgn_r;
  logic [5:0][30:0]         emag_r;
  logic [2:0]               k_r;
  logic [63:0]              prod_r;
  logic [63:0]              ph_r;
  logic [2:0][63:0]         cr_r;
  logic [2:0][NRM_W-1:0]    nrm_r;
  logic [1:0]               j_r;
  logic                     deg_r;
  logic                     out_valid_r;
  logic [2:0][NRM_W-1:0]    onrm_r;
  logic                     odeg_r;

  logic                     in_acc;
  logic                     out_load;
  logic                     a_ok, b_ok, c_ok;
  logic                     pos_we;
  logic [AW-1:0]            pos_raddr;
  logic [3*POS_W-1:0]       pos_rdata;
  logic                     sum_we;
  logic [AW-1:0]            sum_waddr;
  logic [3*SUM_W-1:0]       sum_wdata;
  logic [AW-1:0]            sum_raddr;
  logic [3*SUM_W-1:0]       sum_rdata;
  logic [AW-1:0]            corner;
  logic [3*SUM_W-1:0]       sum_new;
  logic [5:0]               dsgn;
  logic [5:0][30:0]         dmag;
  logic [2:0]               mx, my;
  logic [61:0]              pmag;
  logic [63:0]              prod;
  logic [2:0]               km;
  logic                     norm_start;
  logic [2:0][63:0]         norm_vec;
  norm_res_t                norm_res;

  assign in_acc = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (st_r == S_IDLE);

  // index range checks
  assign a_ok = 32'(ia_r) < VERTEX_COUNT;
  assign b_ok = 32'(ib_r) < VERTEX_COUNT;
  assign c_ok = 32'(ic_r) < VERTEX_COUNT;

  // position store
  assign pos_we    = (st_r == S_WPOS) && a_ok;
  assign pos_raddr = (st_r == S_P0) ? AW'(ia_r) : (st_r == S_P1) ? AW'(ib_r) : AW'(ic_r);

  mvna_ram #(.WIDTH(3*POS_W), .DEPTH(VERTEX_COUNT)) u_pos_ram (
    .clk   (clk),
    .we    (pos_we),
    .waddr (AW'(ia_r)),
    .wdata (pin_r),
    .raddr (pos_raddr),
    .rdata (pos_rdata)
  );

  // accumulator store
  always_comb begin
    case (j_r)
      2'd0:    corner = AW'(ia_r);
      2'd1:    corner = AW'(ib_r);
      default: corner = AW'(ic_r);
    endcase
  end

  // saturating add of the face normal to one corner
  always_comb begin
    logic [SUM_W:0] s;
    sum_new = '0;
    for (int i = 0; i < 3; i++) begin
      s = {sum_rdata[SUM_W*i+SUM_W-1], sum_rdata[SUM_W*i +: SUM_W]}
        + {{(SUM_W+1-NRM_W){nrm_r[i][NRM_W-1]}}, nrm_r[i]};
      if (s[SUM_W:SUM_W-1] == 2'b01) begin
        sum_new[SUM_W*i +: SUM_W] = {1'b0, {(SUM_W-1){1'b1}}};
      end else if (s[SUM_W:SUM_W-1] == 2'b10) begin
        sum_new[SUM_W*i +: SUM_W] = {1'b1, {(SUM_W-1){1'b0}}};
      end else begin
        sum_new[SUM_W*i +: SUM_W] = s[SUM_W-1:0];
      end
    end
  end

  assign sum_we    = (st_r == S_CLR) || (st_r == S_SWR);
  assign sum_waddr = (st_r == S_CLR) ? clr_cnt_r : corner;
  assign sum_wdata = (st_r == S_CLR) ? '0 : sum_new;
  assign sum_raddr = (st_r == S_RSUM) ? AW'(ia_r) : corner;

  mvna_ram #(.WIDTH(3*SUM_W), .DEPTH(VERTEX_COUNT)) u_sum_ram (
    .clk   (clk),
    .we    (sum_we),
    .waddr (sum_waddr),
    .wdata (sum_wdata),
    .raddr (sum_raddr),
    .rdata (sum_rdata)
  );

  // edge vectors as sign and magnitude, halved together when any is too wide
  always_comb begin
    logic [POS_W-1:0] pa;
    logic [POS_W-1:0] po;
    logic [POS_W:0]   d;
    logic [5:0][POS_W:0] mg;
    logic             wide;
    wide = 1'b0;
    for (int i = 0; i < 6; i++) begin
      pa = posa_r[POS_W*(i%3) +: POS_W];
      po = (i < 3) ? posb_r[POS_W*(i%3) +: POS_W] : posc_r[POS_W*(i%3) +: POS_W];
      d  = {po[POS_W-1], po} - {pa[POS_W-1], pa};
      dsgn[i] = d[POS_W];
      mg[i]   = d[POS_W] ? (~d + 33'd1) : d;
      wide    = wide | (|mg[i][POS_W:POS_W-1]);
    end
    for (int i = 0; i < 6; i++) begin
      dmag[i] = wide ? mg[i][31:1] : mg[i][30:0];
    end
  end

  // operand pairs of the cross product
  always_comb begin
    case (k_r)
      3'd0:    begin mx = 3'd1; my = 3'd5; end
      3'd1:    begin mx = 3'd2; my = 3'd4; end
      3'd2:    begin mx = 3'd2; my = 3'd3; end
      3'd3:    begin mx = 3'd0; my = 3'd5; end
      3'd4:    begin mx = 3'd0; my = 3'd4; end
      3'd5:    begin mx = 3'd1; my = 3'd3; end
      default: begin mx = 3'd0; my = 3'd0; end
    endcase
  end

  // shared multiplier
  assign pmag = 62'(emag_r[mx]) * 62'(emag_r[my]);
  assign prod = (esgn_r[mx] ^ esgn_r[my]) ? (~64'(pmag) + 64'd1) : 64'(pmag);
  assign km   = k_r - 3'd1;

  // unit vector engine
  assign norm_start = (st_r == S_NGO);
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      norm_vec[i] = (act_r == ACT_READ)
                  ? {{(64-SUM_W){sum_rdata[SUM_W*i+SUM_W-1]}}, sum_rdata[SUM_W*i +: SUM_W]}
                  : cr_r[i];
    end
  end

  mvna_norm u_norm (
    .clk   (clk),
    .rst_n (rst_n),
    .start (norm_start),
    .vec   (norm_vec),
    .res   (norm_res)
  );

  // main sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_CLR;
      clr_cnt_r   <= '0;
    end else begin
      case (st_r)
        S_CLR: begin
          clr_cnt_r <= clr_cnt_r + AW'(1);
          if (clr_cnt_r == AW'(VERTEX_COUNT - 1)) begin
            st_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            act_r <= in_ch.action;
            ia_r  <= in_ch.index_a;
            ib_r  <= in_ch.index_b;
            ic_r  <= in_ch.index_c;
            pin_r <= {in_ch.pos_z, in_ch.pos_y, in_ch.pos_x};
            case (in_ch.action)
              ACT_WRITE: st_r <= S_WPOS;
              ACT_TRI:   st_r <= S_P0;
              ACT_READ:  st_r <= S_RSUM;
              ACT_CLEAR: begin
                clr_cnt_r <= '0;
                st_r      <= S_CLR;
              end
              default:   st_r <= S_IDLE;
            endcase
          end
        end
        S_WPOS: begin
          st_r <= S_IDLE;
        end
        S_P0: begin
          st_r <= (a_ok && b_ok && c_ok) ? S_P1 : S_IDLE;
        end
        S_P1: begin
          posa_r <= pos_rdata;
          st_r   <= S_P2;
        end
        S_P2: begin
          posb_r <= pos_rdata;
          st_r   <= S_P3;
        end
        S_P3: begin
          posc_r <= pos_rdata;
          st_r   <= S_EDGE;
        end
        S_EDGE: begin
          esgn_r <= dsgn;
          emag_r <= dmag;
          k_r    <= '0;
          st_r   <= S_MUL;
        end
        S_MUL: begin
          if (k_r != 3'd6) begin
            prod_r <= prod;
          end
          if (k_r != 3'd0) begin
            if (!km[0]) begin
              ph_r <= prod_r;
            end else begin
              cr_r[km[2:1]] <= ph_r - prod_r;
            end
          end
          k_r <= k_r + 3'd1;
          if (k_r == 3'd6) begin
            st_r <= S_NGO;
          end
        end
        S_RSUM: begin
          if (a_ok) begin
            st_r <= S_NGO;
          end else begin
            nrm_r <= '0;
            deg_r <= 1'b1;
            st_r  <= S_OUT;
          end
        end
        S_NGO: begin
          st_r <= S_NWAIT;
        end
        S_NWAIT: begin
          if (norm_res.done) begin
            nrm_r <= norm_res.u;
            deg_r <= norm_res.zero;
            j_r   <= '0;
            if (act_r == ACT_READ) begin
              st_r <= S_OUT;
            end else begin
              st_r <= norm_res.zero ? S_IDLE : S_SRD;
            end
          end
        end
        S_SRD: begin
          st_r <= S_SWR;
        end
        S_SWR: begin
          j_r <= j_r + 2'd1;
          st_r <= (j_r == 2'd2) ? S_IDLE : S_SRD;
        end
        S_OUT: begin
          if (out_load) begin
            st_r <= S_IDLE;
          end
        end
        default: begin
          st_r <= S_IDLE;
        end
      endcase
    end
  end

  // output register: loaded from the output state, cleared when taken
  assign out_load = (st_r == S_OUT) && (!out_valid_r || out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
      onrm_r      <= nrm_r;
      odeg_r      <= deg_r;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // result channel
  assign out_ch.valid      = out_valid_r;
  assign out_ch.normal_x   = onrm_r[0];
  assign out_ch.normal_y   = onrm_r[1];
  assign out_ch.normal_z   = onrm_r[2];
  assign out_ch.degenerate = odeg_r;

  // a result is only loaded from the output state
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(st_r == S_OUT))
    else $error("result loaded outside the output state");

  // the unit vector engine only finishes while the sequencer waits for it
  assert property (@(posedge clk) disable iff (!rst_n)
    norm_res.done |-> (st_r == S_NWAIT))
    else $error("unit vector result with no one waiting");

  // an accepted clear item starts the clearing pass at the first entry
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_ch.action == ACT_CLEAR) |=> (st_r == S_CLR && clr_cnt_r == '0))
    else $error("clear item did not start the clearing pass");

endmodule
